// ===== rtl/bmftr_pkg.sv =====
// Package for the bitmap font text renderer.
// Holds field widths, character codes, colours and register indexes.
// Used by bitmap_font_text_renderer_unit; no dependencies of its own.
package bmftr_pkg;

  // Register indexes on the configuration port (byte address = 4 * index).
  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_PIXEL_SCALE = 3'd2;
  localparam logic [2:0] REG_COLUMNS     = 3'd3;
  localparam logic [2:0] REG_TRANSP_BG   = 3'd4;

  // Reset values of the registers and of the cursor.
  localparam logic [7:0]  PIXEL_SCALE_RST = 8'd1;
  localparam logic [7:0]  COLUMNS_RST     = 8'd80;
  localparam logic [15:0] CURSOR_COL_RST  = 16'd1;

  // Character classes and their glyph offsets.
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DIG_LO  = 8'd48;
  localparam logic [7:0] CHAR_DIG_HI  = 8'd57;
  localparam logic [7:0] CHAR_LOW_LO  = 8'd97;
  localparam logic [7:0] CHAR_LOW_HI  = 8'd119;
  localparam logic [7:0] CHAR_UP_LO   = 8'd65;
  localparam logic [7:0] CHAR_UP_HI   = 8'd90;
  localparam logic [6:0] OFFSET_DIGIT = 7'd48;
  localparam logic [6:0] OFFSET_LOWER = 7'd87;
  localparam logic [6:0] OFFSET_UPPER = 7'd55;

  // Each glyph owns 64 store bits; its dots start two bits in.
  localparam int unsigned GLYPH_STRIDE = 64;
  localparam logic [5:0]  DOT_START    = 6'd2;

  localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;
  localparam logic [23:0] COLOR_BLACK = 24'h000000;

  // Shared multiplier: a 20-bit cell count times an 8-bit factor.
  localparam int unsigned MUL_AW = 20;
  localparam int unsigned MUL_BW = 8;
  localparam int unsigned PROD_W = MUL_AW + MUL_BW;
  // Screen coordinates before saturation.
  localparam int unsigned CRD_W  = PROD_W + 1;

endpackage

// ===== rtl/bitmap_font_text_renderer_unit.sv =====
// Bitmap font text renderer: characters in, draw-rectangle words out.
// Depends on bmftr_pkg and on bmftr_ram for the glyph store.
//
// Usage:
//   The input stream (s_axis_*) carries one request per word. tuser = 0 renders
//   a character, tuser = 1 writes one dot of the glyph store. The output stream
//   (m_axis_*) carries one rectangle per drawn font dot, tlast on the final one
//   of a character. The APB port sets origin, scale, columns and transparency;
//   write it only while no character is in progress.
//   A load subtracts the store depth from the address until it fits, then writes
//   the dot. For a render, a small sequencer works out the cell origin with one
//   shared 20x8 multiplier over four steps, then walks the glyph store one dot
//   per cycle while the output does not stall, the store's single read port
//   setting that pace. A space only moves the cursor. s_axis_tready is high
//   only while the sequencer is idle.
//   A stalled receiver holds the walk; the last rectangle of a character may
//   still wait in the output register while the next request is accepted.
//   Reset puts the cursor at column one, row zero and clears the registers to
//   their defaults; the glyph store holds nothing until it is loaded.
module bitmap_font_text_renderer_unit #(
  parameter int unsigned GLYPH_COUNT = 64,
  parameter int unsigned GLYPH_ROWS  = 9,
  parameter int unsigned GLYPH_COLS  = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: char_code[7:0], start_text[8], highlight[9], glyph_addr[21:10],
  //        glyph_byte[29:22], zero[31:30]
  input  logic [31:0] s_axis_tdata,
  // tuser: req_type[0]
  input  logic        s_axis_tuser,
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: rect_x[15:0], rect_y[31:16], rect_size[39:32], rect_color[63:40],
  //        rect_mode[64], zero[71:65]
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned STORE_DEPTH = GLYPH_COUNT * bmftr_pkg::GLYPH_STRIDE;
  localparam int unsigned GW  = $clog2(GLYPH_COUNT);
  localparam int unsigned AW  = GW + 6;
  localparam int unsigned RW  = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int unsigned CLW = (GLYPH_COLS > 1) ? $clog2(GLYPH_COLS) : 1;
  localparam logic [15:0]   DEPTH_16  = 16'(STORE_DEPTH);
  localparam logic [AW-1:0] ADDR_LAST = AW'(STORE_DEPTH - 1);
  localparam logic [RW-1:0]  ROW_LAST = RW'(GLYPH_ROWS - 1);
  localparam logic [CLW-1:0] COL_LAST = CLW'(GLYPH_COLS - 1);
  localparam logic [11:0] GCOUNT_12 = 12'(GLYPH_COUNT);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_GLYPH = 4'd2;
  localparam logic [3:0] S_MCX   = 4'd3;
  localparam logic [3:0] S_MSX   = 4'd4;
  localparam logic [3:0] S_MCY   = 4'd5;
  localparam logic [3:0] S_MSY   = 4'd6;
  localparam logic [3:0] S_ADD   = 4'd7;
  localparam logic [3:0] S_DOT   = 4'd8;
  localparam logic [3:0] S_FLUSH = 4'd9;

  // Configuration registers
  logic [15:0] origin_x_q, origin_y_q;
  logic [7:0]  scale_q, columns_q;
  logic        transp_q;

  // Sequencer and cursor
  logic [3:0]  state_q, state_d;
  logic [15:0] col_q, col_d, row_q, row_d;
  logic [6:0]  offset_q, offset_d;
  logic        hl_q, hl_d;
  logic        ld_bit_q, ld_bit_d;
  logic [11:0] red_q, red_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [RW-1:0]  dot_row_q, dot_row_d;
  logic [CLW-1:0] dot_col_q, dot_col_d;
  logic [bmftr_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [bmftr_pkg::CRD_W-1:0]  xb_q, xb_d, yb_q, yb_d, x_q, x_d, y_q, y_d;

  // Pending rectangle (not yet known whether it is the last) and output word
  logic        pend_valid_q, pend_valid_d;
  logic [15:0] pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic        pend_white_q, pend_white_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic        out_white_q, out_white_d;
  logic        out_mode_q, out_mode_d;
  logic        out_last_q, out_last_d;

  // Shared multiplier operands
  logic [bmftr_pkg::MUL_AW-1:0] mul_a;
  logic [bmftr_pkg::MUL_BW-1:0] mul_b;
  logic [bmftr_pkg::PROD_W-1:0] mul_p;

  logic        ram_we;
  logic        ram_rdata;
  logic        accept, cfg_wr, out_free, draw, stall, dot_final;
  logic [7:0]  in_char;
  logic        in_start, in_hl;
  logic [11:0] in_addr;
  logic [7:0]  in_byte;
  logic [15:0] col_start, row_start, col_inc;
  logic [6:0]  offset_sel;
  logic [7:0]  glyph_raw;
  logic [15:0] cur_x_sat, cur_y_sat;

  assign in_char  = s_axis_tdata[7:0];
  assign in_start = s_axis_tdata[8];
  assign in_hl    = s_axis_tdata[9];
  assign in_addr  = s_axis_tdata[21:10];
  assign in_byte  = s_axis_tdata[29:22];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign pready        = 1'b1;
  assign cfg_wr        = psel & penable & pwrite & pready;

  // Configuration write and read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      scale_q    <= bmftr_pkg::PIXEL_SCALE_RST;
      columns_q  <= bmftr_pkg::COLUMNS_RST;
      transp_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        bmftr_pkg::REG_ORIGIN_X:    origin_x_q <= pwdata[15:0];
        bmftr_pkg::REG_ORIGIN_Y:    origin_y_q <= pwdata[15:0];
        bmftr_pkg::REG_PIXEL_SCALE: scale_q    <= pwdata[7:0];
        bmftr_pkg::REG_COLUMNS:     columns_q  <= pwdata[7:0];
        bmftr_pkg::REG_TRANSP_BG:   transp_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      bmftr_pkg::REG_ORIGIN_X:    prdata = {16'd0, origin_x_q};
      bmftr_pkg::REG_ORIGIN_Y:    prdata = {16'd0, origin_y_q};
      bmftr_pkg::REG_PIXEL_SCALE: prdata = {24'd0, scale_q};
      bmftr_pkg::REG_COLUMNS:     prdata = {24'd0, columns_q};
      bmftr_pkg::REG_TRANSP_BG:   prdata = {31'd0, transp_q};
      default:                    prdata = '0;
    endcase
  end

  // The one multiplier: a cell index times the glyph size, then that times
  // the pixel scale.
  always_comb begin
    case (state_q)
      S_MCX:   begin mul_a = 20'(col_q);  mul_b = 8'(GLYPH_COLS); end
      S_MCY:   begin mul_a = 20'(row_q);  mul_b = 8'(GLYPH_ROWS); end
      S_MSX,
      S_MSY:   begin mul_a = prod_q[bmftr_pkg::MUL_AW-1:0]; mul_b = scale_q; end
      default: begin mul_a = '0;          mul_b = '0;             end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Character class picks the offset; other codes keep the last one.
  always_comb begin
    if (in_char >= bmftr_pkg::CHAR_DIG_LO && in_char <= bmftr_pkg::CHAR_DIG_HI) begin
      offset_sel = bmftr_pkg::OFFSET_DIGIT;
    end else if (in_char >= bmftr_pkg::CHAR_LOW_LO && in_char <= bmftr_pkg::CHAR_LOW_HI) begin
      offset_sel = bmftr_pkg::OFFSET_LOWER;
    end else if (in_char >= bmftr_pkg::CHAR_UP_LO && in_char <= bmftr_pkg::CHAR_UP_HI) begin
      offset_sel = bmftr_pkg::OFFSET_UPPER;
    end else begin
      offset_sel = offset_q;
    end
  end
  assign glyph_raw = in_char - {1'b0, offset_sel};

  assign col_start = in_start ? bmftr_pkg::CURSOR_COL_RST : col_q;
  assign row_start = in_start ? 16'd0 : row_q;
  assign col_inc   = col_q + 16'd1;

  assign cur_x_sat = (|x_q[bmftr_pkg::CRD_W-1:16]) ? 16'hFFFF : x_q[15:0];
  assign cur_y_sat = (|y_q[bmftr_pkg::CRD_W-1:16]) ? 16'hFFFF : y_q[15:0];

  assign out_free  = ~out_valid_q | m_axis_tready;
  assign draw      = ram_rdata | ~transp_q;
  assign stall     = draw & pend_valid_q & ~out_free;
  assign dot_final = (dot_row_q == ROW_LAST) && (dot_col_q == COL_LAST);

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    offset_d     = offset_q;
    hl_d         = hl_q;
    ld_bit_d     = ld_bit_q;
    red_d        = red_q;
    addr_d       = addr_q;
    dot_row_d    = dot_row_q;
    dot_col_d    = dot_col_q;
    prod_d       = prod_q;
    xb_d         = xb_q;
    yb_d         = yb_q;
    x_d          = x_q;
    y_d          = y_q;
    pend_valid_d = pend_valid_q;
    pend_x_d     = pend_x_q;
    pend_y_d     = pend_y_q;
    pend_white_d = pend_white_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_white_d  = out_white_q;
    out_mode_d   = out_mode_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser) begin
            red_d    = in_addr;
            ld_bit_d = |in_byte;
            state_d  = S_LOAD;
          end else if (in_char == bmftr_pkg::CHAR_SPACE) begin
            col_d = col_start + 16'd1;
            row_d = row_start;
          end else begin
            col_d    = col_start;
            row_d    = row_start;
            offset_d = offset_sel;
            hl_d     = in_hl;
            red_d    = {4'd0, glyph_raw};
            state_d  = S_GLYPH;
          end
        end
      end
      S_LOAD: begin
        // Fold the address into the store depth, then write.
        if ({4'd0, red_q} >= DEPTH_16) begin
          red_d = red_q - DEPTH_16[11:0];
        end else begin
          ram_we  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_GLYPH: begin
        if (red_q >= GCOUNT_12) begin
          red_d = red_q - GCOUNT_12;
        end else begin
          addr_d  = {red_q[GW-1:0], bmftr_pkg::DOT_START};
          state_d = S_MCX;
        end
      end
      S_MCX: begin
        prod_d  = mul_p;
        state_d = S_MSX;
      end
      S_MSX: begin
        prod_d  = mul_p;
        xb_d    = {{(bmftr_pkg::CRD_W-16){1'b0}}, origin_x_q};
        state_d = S_MCY;
      end
      S_MCY: begin
        xb_d    = xb_q + bmftr_pkg::CRD_W'(prod_q);
        prod_d  = mul_p;
        state_d = S_MSY;
      end
      S_MSY: begin
        prod_d  = mul_p;
        state_d = S_ADD;
      end
      S_ADD: begin
        yb_d      = bmftr_pkg::CRD_W'(origin_y_q) + bmftr_pkg::CRD_W'(prod_q);
        y_d       = bmftr_pkg::CRD_W'(origin_y_q) + bmftr_pkg::CRD_W'(prod_q);
        x_d       = xb_q;
        dot_row_d = '0;
        dot_col_d = '0;
        state_d   = S_DOT;
      end
      S_DOT: begin
        // The store's read data belongs to the dot at addr_q.
        if (!stall) begin
          if (draw) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_x_d     = pend_x_q;
              out_y_d     = pend_y_q;
              out_white_d = pend_white_q;
              out_mode_d  = ~hl_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_x_d     = cur_x_sat;
            pend_y_d     = cur_y_sat;
            pend_white_d = ram_rdata | hl_q;
          end
          addr_d = (addr_q == ADDR_LAST) ? '0 : addr_q + AW'(1);
          if (dot_col_q == COL_LAST) begin
            dot_col_d = '0;
            dot_row_d = dot_row_q + RW'(1);
            x_d       = xb_q;
            y_d       = y_q + bmftr_pkg::CRD_W'(scale_q);
          end else begin
            dot_col_d = dot_col_q + CLW'(1);
            x_d       = x_q + bmftr_pkg::CRD_W'(scale_q);
          end
          if (dot_final) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_valid_d  = 1'b1;
            out_x_d      = pend_x_q;
            out_y_d      = pend_y_q;
            out_white_d  = pend_white_q;
            out_mode_d   = ~hl_q;
            out_last_d   = 1'b1;
            pend_valid_d = 1'b0;
          end
          if (col_inc >= {8'd0, columns_q}) begin
            col_d = '0;
            row_d = row_q + 16'd1;
          end else begin
            col_d = col_inc;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      col_q        <= bmftr_pkg::CURSOR_COL_RST;
      row_q        <= '0;
      offset_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      row_q        <= row_d;
      offset_q     <= offset_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hl_q         <= hl_d;
    ld_bit_q     <= ld_bit_d;
    red_q        <= red_d;
    addr_q       <= addr_d;
    dot_row_q    <= dot_row_d;
    dot_col_q    <= dot_col_d;
    prod_q       <= prod_d;
    xb_q         <= xb_d;
    yb_q         <= yb_d;
    x_q          <= x_d;
    y_q          <= y_d;
    pend_x_q     <= pend_x_d;
    pend_y_q     <= pend_y_d;
    pend_white_q <= pend_white_d;
    out_x_q      <= out_x_d;
    out_y_q      <= out_y_d;
    out_white_q  <= out_white_d;
    out_mode_q   <= out_mode_d;
    out_last_q   <= out_last_d;
  end

  // The read address follows the next dot address, so the read data in the
  // walk always belongs to the current dot.
  bmftr_ram #(
    .WIDTH(1),
    .DEPTH(STORE_DEPTH)
  ) u_glyph_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(red_q)),
    .wdata_i(ld_bit_q),
    .raddr_i(addr_d),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0,
                          out_mode_q,
                          out_white_q ? bmftr_pkg::COLOR_WHITE : bmftr_pkg::COLOR_BLACK,
                          scale_q,
                          out_y_q,
                          out_x_q};

endmodule

// ===== rtl/bmftr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the glyph store of the text renderer; no dependencies.
module bmftr_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
